// ----- rtl/lds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lds_pkg
// Shared widths, codes, controller states and the controller/datapath
// command and status groups of the LOOK disk request scheduler.
// ----------------------------------------------------------------------------
package lds_pkg;

	localparam int SECTOR_W        = 48;
	localparam int LENGTH_W        = 16;
	localparam int TAG_W           = 8;
	localparam int PEND_W          = 5;
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic ACT_ADD      = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_DISP_SCAN,
		ST_DISP_DRAIN,
		ST_DISP_PICK
	} lds_state_t;

	typedef struct packed {
		logic load;      // latch request beat, rewind scan
		logic cnt_inc;   // step slot index
		logic rd_en;     // read slot at index
		logic res_add;   // store request in slot at index
		logic res_drop;  // table full
		logic res_pick;  // commit LOOK choice
	} lds_cmd_t;

	typedef struct packed {
		logic in_dispatch; // action of the offered beat
		logic full;
		logic empty;
		logic slot_free;   // slot at index is free
		logic cnt_last;
		logic out_free;    // result register can take a value
	} lds_status_t;

endpackage
`default_nettype wire

// ----- rtl/lds_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lds_req_if
// Request channel: add or dispatch beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lds_req_if import lds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [SECTOR_W-1:0] request_sector;
	logic [LENGTH_W-1:0] request_length;
	logic [TAG_W-1:0]    request_tag;

	modport source (output valid, action, request_sector, request_length, request_tag,
		input ready);
	modport sink (input valid, action, request_sector, request_length, request_tag,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/lds_res_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lds_res_if
// Result channel: one beat per request beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lds_res_if import lds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                granted;
	logic [SECTOR_W-1:0] served_sector;
	logic [LENGTH_W-1:0] served_length;
	logic [TAG_W-1:0]    served_tag;
	logic                dropped;
	logic                moving_up;
	logic [PEND_W-1:0]   pending_count;

	modport source (output valid, granted, served_sector, served_length, served_tag,
		dropped, moving_up, pending_count, input ready);
	modport sink (input valid, granted, served_sector, served_length, served_tag,
		dropped, moving_up, pending_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/lds_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lds_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lds_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lds_ctrl
// Sequencer: free-slot scan for adds, full table scan and pick for
// dispatches, one beat in flight at a time.
// ----------------------------------------------------------------------------
module lds_ctrl import lds_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire lds_status_t st,
	output lds_cmd_t         cmd
);

	lds_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = st.in_dispatch ? ST_DISP_SCAN : ST_ADD_SCAN;
				end
			end
			ST_ADD_SCAN: begin
				if ((st.full || st.slot_free) && st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DISP_SCAN: begin
				if (st.empty) begin
					state_d = ST_DISP_PICK;
				end else if (st.cnt_last) begin
					state_d = ST_DISP_DRAIN;
				end
			end
			ST_DISP_DRAIN: begin
				state_d = ST_DISP_PICK;
			end
			ST_DISP_PICK: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ADD_SCAN: begin
				if (st.full) begin
					cmd.res_drop = st.out_free;
				end else if (st.slot_free) begin
					cmd.res_add = st.out_free;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_DISP_SCAN: begin
				if (!st.empty) begin
					cmd.rd_en   = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_DISP_PICK: begin
				cmd.res_pick = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_res_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.res_add, cmd.res_drop, cmd.res_pick}))
		else $error("more than one result command");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_add || cmd.res_drop || cmd.res_pick) |-> st.out_free)
		else $error("result issued while result register busy");
	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_add |-> !st.full && st.slot_free)
		else $error("add into full table or used slot");

endmodule
`default_nettype wire

// ----- rtl/lds_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lds_dpath
// Slot store, valid bits, head and sweep state, scan compare and the
// result register.
// ----------------------------------------------------------------------------
module lds_dpath import lds_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lds_cmd_t            cmd,
	output lds_status_t              st,
	input  wire logic                in_action,
	input  wire logic [SECTOR_W-1:0] in_sector,
	input  wire logic [LENGTH_W-1:0] in_length,
	input  wire logic [TAG_W-1:0]    in_tag,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     out_granted,
	output logic      [SECTOR_W-1:0] out_sector,
	output logic      [LENGTH_W-1:0] out_length,
	output logic      [TAG_W-1:0]    out_tag,
	output logic                     out_dropped,
	output logic                     out_moving_up,
	output logic      [PEND_W-1:0]   out_pending
);

	localparam int IW  = $clog2(QUEUE_DEPTH);
	localparam int PCW = $clog2(QUEUE_DEPTH + 1);
	localparam int WW  = SECTOR_W + LENGTH_W + TAG_W;

	logic [SECTOR_W-1:0]    sec_in_q;
	logic [LENGTH_W-1:0]    len_in_q;
	logic [TAG_W-1:0]       tag_in_q;
	logic [IW-1:0]          cnt_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [PCW-1:0]         count_q;
	logic [SECTOR_W-1:0]    head_q;
	logic                   sweep_q;

	logic                   rd_vld_s1;
	logic                   slot_vld_s1;
	logic [IW-1:0]          idx_s1;
	logic [WW-1:0]          rdata;
	logic [SECTOR_W-1:0]    sec_s1;
	logic [LENGTH_W-1:0]    len_s1;
	logic [TAG_W-1:0]       tag_s1;

	logic                   have_up_q, have_dn_q;
	logic [SECTOR_W-1:0]    up_sec_q, dn_sec_q;
	logic [LENGTH_W-1:0]    up_len_q, dn_len_q;
	logic [TAG_W-1:0]       up_tag_q, dn_tag_q;
	logic [IW-1:0]          up_idx_q, dn_idx_q;

	logic                   out_valid_q;

	logic                   cand, up_hit, dn_hit;
	logic                   granted, take_up, new_sweep;
	logic [SECTOR_W-1:0]    pk_sec;
	logic [LENGTH_W-1:0]    pk_len;
	logic [TAG_W-1:0]       pk_tag;
	logic [IW-1:0]          pk_idx;
	logic [PCW-1:0]         count_add, count_pick;

	lds_ram #(
		.WIDTH(WW),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (cmd.res_add),
		.waddr(cnt_q),
		.wdata({tag_in_q, len_in_q, sec_in_q}),
		.re   (cmd.rd_en),
		.raddr(cnt_q),
		.rdata(rdata)
	);

	assign sec_s1 = rdata[SECTOR_W-1:0];
	assign len_s1 = rdata[SECTOR_W +: LENGTH_W];
	assign tag_s1 = rdata[SECTOR_W+LENGTH_W +: TAG_W];

	assign st.in_dispatch = (in_action == ACT_DISPATCH);
	assign st.full        = (count_q == PCW'(QUEUE_DEPTH));
	assign st.empty       = (count_q == '0);
	assign st.slot_free   = !valid_q[cnt_q];
	assign st.cnt_last    = (cnt_q == IW'(QUEUE_DEPTH - 1));
	assign st.out_free    = !out_valid_q || out_ready;

	// scan compare, ascending slots so strict tests keep the lowest slot on ties
	assign cand   = rd_vld_s1 && slot_vld_s1;
	assign up_hit = cand && (sec_s1 >= head_q) && (!have_up_q || (sec_s1 < up_sec_q));
	assign dn_hit = cand && (sec_s1 < head_q) && (!have_dn_q || (sec_s1 > dn_sec_q));

	assign granted   = have_up_q || have_dn_q;
	assign take_up   = sweep_q ? have_up_q : !have_dn_q;
	assign new_sweep = granted ? take_up : sweep_q;
	assign pk_sec    = take_up ? up_sec_q : dn_sec_q;
	assign pk_len    = take_up ? up_len_q : dn_len_q;
	assign pk_tag    = take_up ? up_tag_q : dn_tag_q;
	assign pk_idx    = take_up ? up_idx_q : dn_idx_q;

	assign count_add  = count_q + PCW'(1);
	assign count_pick = granted ? count_q - PCW'(1) : count_q;

	function automatic logic [PEND_W-1:0] sat_pend(input logic [PCW-1:0] n);
		logic [PEND_W-1:0] r;
		if (PCW > PEND_W && n > PCW'((1 << PEND_W) - 1)) begin
			r = '1;
		end else begin
			r = PEND_W'(n);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sec_in_q <= in_sector;
			len_in_q <= in_length;
			tag_in_q <= in_tag;
		end
		idx_s1      <= cnt_q;
		slot_vld_s1 <= valid_q[cnt_q];
		if (up_hit) begin
			up_sec_q <= sec_s1;
			up_len_q <= len_s1;
			up_tag_q <= tag_s1;
			up_idx_q <= idx_s1;
		end
		if (dn_hit) begin
			dn_sec_q <= sec_s1;
			dn_len_q <= len_s1;
			dn_tag_q <= tag_s1;
			dn_idx_q <= idx_s1;
		end
		if (cmd.res_add || cmd.res_drop || cmd.res_pick) begin
			out_granted   <= cmd.res_pick && granted;
			out_sector    <= (cmd.res_pick && granted) ? pk_sec : '0;
			out_length    <= (cmd.res_pick && granted) ? pk_len : '0;
			out_tag       <= (cmd.res_pick && granted) ? pk_tag : '0;
			out_dropped   <= cmd.res_drop;
			out_moving_up <= cmd.res_pick ? new_sweep : sweep_q;
			out_pending   <= sat_pend(cmd.res_add ? count_add :
				(cmd.res_pick ? count_pick : count_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			head_q      <= '0;
			sweep_q     <= 1'b1;
			rd_vld_s1   <= 1'b0;
			have_up_q   <= 1'b0;
			have_dn_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.load) begin
				cnt_q     <= '0;
				have_up_q <= 1'b0;
				have_dn_q <= 1'b0;
			end else begin
				if (cmd.cnt_inc) begin
					cnt_q <= cnt_q + IW'(1);
				end
				if (up_hit) begin
					have_up_q <= 1'b1;
				end
				if (dn_hit) begin
					have_dn_q <= 1'b1;
				end
			end
			if (cmd.res_add) begin
				valid_q[cnt_q] <= 1'b1;
				count_q        <= count_add;
			end
			if (cmd.res_pick && granted) begin
				valid_q[pk_idx] <= 1'b0;
				count_q         <= count_pick;
				head_q          <= pk_sec + SECTOR_W'(pk_len);
				sweep_q         <= new_sweep;
			end
			if (cmd.res_add || cmd.res_drop || cmd.res_pick) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == PCW'($countones(valid_q)))
		else $error("pending count out of step with valid bits");
	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_pick && granted) |-> valid_q[pk_idx])
		else $error("picked slot not pending");
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_granted && out_dropped))
		else $error("result both granted and dropped");

endmodule
`default_nettype wire

// ----- rtl/look_disk_request_scheduler_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// look_disk_request_scheduler_top
// LOOK elevator scheduler over a table of QUEUE_DEPTH disk requests.
// ----------------------------------------------------------------------------
// Request beats on req carry an action: add stores sector, length and tag in
// the lowest free slot (or reports dropped when the table is full); dispatch
// serves the next request by the LOOK rule and moves the head to
// sector + length. Every request beat yields exactly one result beat on res,
// with the sweep direction and pending count after the beat.
// One request is worked on at a time. An add scans the slots upward from
// slot 0 to the lowest free slot, with no scan when the table is full. A
// dispatch reads the whole slot RAM, one slot per cycle, then picks; a
// dispatch on an empty table skips the scan and goes straight to the pick.
// Results sit in an output register; a new request is accepted while a
// result waits, and a stalled res only holds the block when the next result
// is ready to be written.
// Reset clears all valid bits, sets the head to sector 0 and the sweep to
// upward; slot contents need no clearing.
// ----------------------------------------------------------------------------
module look_disk_request_scheduler_top import lds_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lds_req_if.sink  req,
	lds_res_if.source res
);

	lds_cmd_t    cmd;
	lds_status_t st;

	lds_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.st      (st),
		.cmd     (cmd)
	);

	lds_dpath #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.in_action    (req.action),
		.in_sector    (req.request_sector),
		.in_length    (req.request_length),
		.in_tag       (req.request_tag),
		.out_valid    (res.valid),
		.out_ready    (res.ready),
		.out_granted  (res.granted),
		.out_sector   (res.served_sector),
		.out_length   (res.served_length),
		.out_tag      (res.served_tag),
		.out_dropped  (res.dropped),
		.out_moving_up(res.moving_up),
		.out_pending  (res.pending_count)
	);

endmodule
`default_nettype wire
